// ===== design/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // configuration register width and register indexes
    localparam int CFG_BITS = 12;
    localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

    // reset values of the screen size registers
    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = 12'd480;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // color index width
    localparam int COLOR_BITS = 4;

    // decision variable constants of the midpoint loop
    localparam int DEC_INIT      = 3;
    localparam int DEC_STEP_DIAG = 10;
    localparam int DEC_STEP_AXIS = 6;

    // points per step and index of the final one
    localparam int         PT_IDX_BITS = 3;
    localparam logic [2:0] PT_IDX_LAST = 3'd7;

    // kind of work handed from front to back
    typedef enum logic [0:0] {
        JOB_EIGHT = 1'b0,   // eight symmetric points
        JOB_IDLE  = 1'b1    // single empty point, step after completion
    } t_job_kind;

    typedef struct packed {
        t_job_kind kind;
        logic      done;
    } t_job_ctl;

    localparam int CTL_BITS = $bits(t_job_ctl);

endpackage

// ===== design/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front
// Command front end: takes start/step requests, walks the octant state
// (x, y, decision) and pushes one job per request into the job queue.
// ----------------------------------------------------------------------------
module mcr_front #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10,
    parameter int OCT_BITS    = RADIUS_BITS + 2,
    parameter int JOB_BITS    = mcr_pkg::CTL_BITS + mcr_pkg::COLOR_BITS
                                + 2 * COORD_BITS + 2 * OCT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic                             i_command,
    input  logic [COORD_BITS-1:0]            i_center_x,
    input  logic [COORD_BITS-1:0]            i_center_y,
    input  logic [RADIUS_BITS-1:0]           i_radius,
    input  logic [mcr_pkg::COLOR_BITS-1:0]   i_pen_color,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output logic [JOB_BITS-1:0]              o_q_data
);
    import mcr_pkg::*;

    localparam int DEC_BITS = RADIUS_BITS + 4;

    // held circle and walker state
    logic [COORD_BITS-1:0]       r_cx, n_cx;
    logic [COORD_BITS-1:0]       r_cy, n_cy;
    logic [COLOR_BITS-1:0]       r_color, n_color;
    logic signed [OCT_BITS-1:0]  r_x, n_x;
    logic signed [OCT_BITS-1:0]  r_y, n_y;
    logic signed [DEC_BITS-1:0]  r_d, n_d;
    logic                        r_busy, n_busy;

    logic                        w_accept;
    logic signed [OCT_BITS-1:0]  w_nx, w_ny;
    logic signed [DEC_BITS-1:0]  w_nx_d, w_ny_d, w_nd;
    logic                        w_d_pos;
    logic                        w_finished;
    t_job_ctl                    w_ctl;
    logic [COORD_BITS-1:0]       w_job_cx, w_job_cy;
    logic [COLOR_BITS-1:0]       w_job_color;
    logic signed [OCT_BITS-1:0]  w_job_a, w_job_b;

    assign w_accept = i_push && !i_q_full;
    assign o_q_push = w_accept;

    // one iteration of the midpoint loop
    assign w_d_pos    = !r_d[DEC_BITS-1] && (r_d != '0);
    assign w_nx       = r_x + {{(OCT_BITS-1){1'b0}}, 1'b1};
    assign w_ny       = w_d_pos ? (r_y - {{(OCT_BITS-1){1'b0}}, 1'b1}) : r_y;
    assign w_nx_d     = DEC_BITS'(w_nx);
    assign w_ny_d     = DEC_BITS'(w_ny);
    assign w_nd       = w_d_pos ? (r_d + ((w_nx_d - w_ny_d) <<< 2) + DEC_BITS'(DEC_STEP_DIAG))
                                : (r_d + (w_nx_d <<< 2) + DEC_BITS'(DEC_STEP_AXIS));
    assign w_finished = !r_busy || (r_y < r_x);

    // next state and job contents
    always_comb begin
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_color     = r_color;
        n_x         = r_x;
        n_y         = r_y;
        n_d         = r_d;
        n_busy      = r_busy;
        w_ctl.kind  = JOB_EIGHT;
        w_ctl.done  = 1'b0;
        w_job_cx    = r_cx;
        w_job_cy    = r_cy;
        w_job_color = r_color;
        w_job_a     = r_x;
        w_job_b     = r_y;
        if (i_command == CMD_START) begin
            n_cx        = i_center_x;
            n_cy        = i_center_y;
            n_color     = i_pen_color;
            n_x         = '0;
            n_y         = {2'b00, i_radius};
            n_d         = DEC_BITS'(DEC_INIT) - {3'b000, i_radius, 1'b0};
            n_busy      = 1'b1;
            w_job_cx    = i_center_x;
            w_job_cy    = i_center_y;
            w_job_color = i_pen_color;
            w_job_a     = '0;
            w_job_b     = {2'b00, i_radius};
        end else if (w_finished) begin
            n_busy     = 1'b0;
            w_ctl.kind = JOB_IDLE;
            w_ctl.done = 1'b1;
        end else begin
            n_x        = w_nx;
            n_y        = w_ny;
            n_d        = w_nd;
            n_busy     = !(w_ny < w_nx);
            w_ctl.done = (w_ny < w_nx);
            w_job_a    = w_nx;
            w_job_b    = w_ny;
        end
    end

    assign o_q_data = {w_ctl, w_job_color, w_job_cx, w_job_cy, w_job_a, w_job_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_color <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_d     <= '0;
            r_busy  <= 1'b0;
        end else if (w_accept) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_color <= n_color;
            r_x     <= n_x;
            r_y     <= n_y;
            r_d     <= n_d;
            r_busy  <= n_busy;
        end
    end

endmodule

// ===== design/mcr_queue.sv =====
// ----------------------------------------------------------------------------
// mcr_queue
// Two-entry job queue between the command front end and the point back end.
// ----------------------------------------------------------------------------
module mcr_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output logic [DATA_BITS-1:0] o_data
);
    import mcr_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    logic [DATA_BITS-1:0] r_mem [2];
    logic                 r_wptr, r_rptr;
    logic [1:0]           r_count, n_count;

    assign o_full  = (r_count == DEPTH);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== design/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back
// Point back end: expands the job at the queue head into its points, one per
// cycle while the result register is free or drains, clips each against the screen
// and holds it in the result register.
module mcr_back #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10,
    parameter int OCT_BITS    = RADIUS_BITS + 2,
    parameter int JOB_BITS    = mcr_pkg::CTL_BITS + mcr_pkg::COLOR_BITS
                                + 2 * COORD_BITS + 2 * OCT_BITS,
    parameter int OUT_BITS    = COORD_BITS + 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  logic [JOB_BITS-1:0]              i_q_data,
    output logic                             o_q_pop,
    input  logic [mcr_pkg::CFG_BITS-1:0]     i_screen_width,
    input  logic [mcr_pkg::CFG_BITS-1:0]     i_screen_height,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic signed [OUT_BITS-1:0]       o_point_x,
    output logic signed [OUT_BITS-1:0]       o_point_y,
    output logic [mcr_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                             o_visible,
    output logic                             o_last_point,
    output logic                             o_done_res
);
    import mcr_pkg::*;

    localparam int MAX_CR   = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
    localparam int SUM_BITS = (MAX_CR + 3 > CFG_BITS + 2) ? MAX_CR + 3 : CFG_BITS + 2;
    localparam int B_LO     = 0;
    localparam int A_LO     = OCT_BITS;
    localparam int CY_LO    = 2 * OCT_BITS;
    localparam int CX_LO    = CY_LO + COORD_BITS;
    localparam int COL_LO   = CX_LO + COORD_BITS;

    // job fields at the queue head
    t_job_ctl                    w_ctl;
    logic [COLOR_BITS-1:0]       w_color;
    logic [COORD_BITS-1:0]       w_cx, w_cy;
    logic signed [OCT_BITS-1:0]  w_a, w_b;

    assign w_ctl   = i_q_data[JOB_BITS-1 -: CTL_BITS];
    assign w_color = i_q_data[COL_LO +: COLOR_BITS];
    assign w_cx    = i_q_data[CX_LO +: COORD_BITS];
    assign w_cy    = i_q_data[CY_LO +: COORD_BITS];
    assign w_a     = i_q_data[A_LO +: OCT_BITS];
    assign w_b     = i_q_data[B_LO +: OCT_BITS];

    logic [PT_IDX_BITS-1:0]      r_idx;
    logic                        r_valid;
    logic signed [OUT_BITS-1:0]  r_px, r_py;
    logic [COLOR_BITS-1:0]       r_color;
    logic                        r_vis, r_last, r_done;

    logic                        w_adv, w_job_end;
    logic signed [OCT_BITS-1:0]  w_dx, w_dy;
    logic signed [SUM_BITS-1:0]  w_dx_s, w_dy_s, w_cx_s, w_cy_s, w_px, w_py;
    logic signed [SUM_BITS-1:0]  w_wid_s, w_hgt_s;
    logic                        w_vis;

    // advance when a job waits and the result register is free or drains
    assign w_adv     = !i_q_empty && (!r_valid || i_pop);
    assign w_job_end = (w_ctl.kind == JOB_IDLE) || (r_idx == PT_IDX_LAST);
    assign o_q_pop   = w_adv && w_job_end;

    // symmetric point: bit 2 swaps axes, bit 0 mirrors x, bit 1 mirrors y
    assign w_dx   = r_idx[2] ? w_b : w_a;
    assign w_dy   = r_idx[2] ? w_a : w_b;
    assign w_dx_s = SUM_BITS'(w_dx);
    assign w_dy_s = SUM_BITS'(w_dy);
    assign w_cx_s = signed'({{(SUM_BITS-COORD_BITS){1'b0}}, w_cx});
    assign w_cy_s = signed'({{(SUM_BITS-COORD_BITS){1'b0}}, w_cy});
    assign w_px   = r_idx[0] ? (w_cx_s - w_dx_s) : (w_cx_s + w_dx_s);
    assign w_py   = r_idx[1] ? (w_cy_s - w_dy_s) : (w_cy_s + w_dy_s);

    // screen clip
    assign w_wid_s = signed'({{(SUM_BITS-CFG_BITS){1'b0}}, i_screen_width});
    assign w_hgt_s = signed'({{(SUM_BITS-CFG_BITS){1'b0}}, i_screen_height});
    assign w_vis   = !w_px[SUM_BITS-1] && !w_py[SUM_BITS-1]
                     && (w_px < w_wid_s) && (w_py < w_hgt_s);

    // point index and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_idx   <= w_job_end ? '0 : r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_ctl.kind == JOB_IDLE) begin
                r_px    <= '0;
                r_py    <= '0;
                r_color <= '0;
                r_vis   <= 1'b0;
                r_last  <= 1'b1;
                r_done  <= 1'b1;
            end else begin
                r_px    <= w_px[OUT_BITS-1:0];
                r_py    <= w_py[OUT_BITS-1:0];
                r_color <= w_color;
                r_vis   <= w_vis;
                r_last  <= (r_idx == PT_IDX_LAST);
                r_done  <= w_ctl.done;
            end
        end
    end

    assign o_empty       = !r_valid;
    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_pixel_color = r_color;
    assign o_visible     = r_vis;
    assign o_last_point  = r_last;
    assign o_done_res    = r_done;

endmodule

// ===== design/midpoint_circle_rasterizer_unit.sv =====
// A request reaches the result side through a job queue entry and then the result register.
// A start or step request yields eight points, a step after completion one empty point;
// the back end produces one point per cycle from the job queue head while the result register is free or drains.
// The front end keeps taking requests while the two-entry job queue has room.
// Reset: synchronous, active low; clears the walker, the job queue and the result valid
// flag, and loads the screen size registers with 640 by 480.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle outline generator: front end walks the octant, back end
// emits eight clipped symmetric points per step, or one empty point after completion.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request side
    input  logic                             i_push,
    output logic                             o_full,
    input  logic                             i_command,
    input  logic [COORD_BITS-1:0]            i_center_x,
    input  logic [COORD_BITS-1:0]            i_center_y,
    input  logic [RADIUS_BITS-1:0]           i_radius,
    input  logic [mcr_pkg::COLOR_BITS-1:0]   i_pen_color,
    // result side
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic signed [COORD_BITS+1:0]     o_point_x,
    output logic signed [COORD_BITS+1:0]     o_point_y,
    output logic [mcr_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                             o_visible,
    output logic                             o_last_point,
    output logic                             o_done_res,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_index,
    input  logic [mcr_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import mcr_pkg::*;

    localparam int OCT_BITS = RADIUS_BITS + 2;
    localparam int OUT_BITS = COORD_BITS + 2;
    localparam int JOB_BITS = CTL_BITS + COLOR_BITS + 2 * COORD_BITS + 2 * OCT_BITS;

    logic [CFG_BITS-1:0] r_screen_width, r_screen_height;

    logic                w_q_push, w_q_pop, w_q_full, w_q_empty;
    logic [JOB_BITS-1:0] w_q_in, w_q_out;

    // screen size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_full = w_q_full;

    mcr_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .OCT_BITS    (OCT_BITS),
        .JOB_BITS    (JOB_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_command   (i_command),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .i_pen_color (i_pen_color),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_in)
    );

    mcr_queue #(
        .DATA_BITS (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_q_out)
    );

    mcr_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .OCT_BITS    (OCT_BITS),
        .JOB_BITS    (JOB_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_q_data        (w_q_out),
        .o_q_pop         (w_q_pop),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_pixel_color   (o_pixel_color),
        .o_visible       (o_visible),
        .o_last_point    (o_last_point),
        .o_done_res      (o_done_res)
    );

`ifndef SYNTHESIS
    // back end only retires a job that is present
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("job queue popped while empty");

    // queue cannot be full and empty at once
    a_q_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("job queue flags inconsistent");

    // inside a job the next point follows without a gap
    a_job_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_last_point && i_pop) |=> !o_empty)
        else $error("gap inside an eight point burst");
`endif

endmodule
